// File: rtl/core/tdps_pkg.sv
package tdps_pkg;

  // Fixed widths of the port fields and the configuration register index
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 2'd1;

  // Register values after reset
  localparam logic [FIELD_W-1:0] LOWER_BOUND_RST = 16'd0;
  localparam logic [FIELD_W-1:0] UPPER_BOUND_RST = 16'd49999;

  // Scan sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TEST,
    S_DIV,
    S_DONE
  } state_t;

  // Status from the remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

  // Control strobes from the sequencer to the datapath
  typedef struct packed {
    logic load_pos;
    logic cand_inc;
    logic div_init;
    logic div_adv;
    logic rem_start;
    logic res_prime;
    logic res_none;
    logic out_load;
  } ctrl_t;

endpackage

// File: rtl/core/tdps_rem_unit.sv
module tdps_rem_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   dividend,
  input  logic [VALUE_BITS-1:0]   divisor,
  output tdps_pkg::rem_stat_t     stat
);
  import tdps_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [VALUE_BITS-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   rem_shift;
  logic [VALUE_BITS:0]   rem_diff;

  // One restoring step: bring in the next dividend bit, subtract when it fits
  assign rem_shift = {rem_r, dvd_r[VALUE_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_diff[VALUE_BITS]) begin
        rem_nxt = rem_shift[VALUE_BITS-1:0];
      end else begin
        rem_nxt = rem_diff[VALUE_BITS-1:0];
      end
      dvd_nxt = {dvd_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state under reset, operands need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

// File: rtl/core/trial_division_prime_scan.sv
// The run time of a request grows with the candidates tested and the divisors tried on each;
//   each divisor test runs through the bit-serial remainder unit.
// Throughput: one word in flight; a new request is taken once the previous result is in
//   the output register, which may still be waiting on out_stall.
// Reset (rst_n low, synchronous): bounds return to 0 and 49999, the scan position clears
//   and the first request loads the position from the lower bound.
module trial_division_prime_scan #(
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tdps_pkg::FIELD_W-1:0]    out_prime_value,
  output logic                            out_found,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tdps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdps_pkg::FIELD_W-1:0]    cfg_data
);
  import tdps_pkg::*;

  localparam int CAND_W = VALUE_BITS + 1;
  localparam int SQ_W   = VALUE_BITS + 2;

  state_t                state_r, state_nxt;
  ctrl_t                 ctrl;
  rem_stat_t             rem_stat;

  logic [FIELD_W-1:0]    lower_r, upper_r;
  logic [CAND_W-1:0]     cand_r;
  logic                  started_r;
  logic [VALUE_BITS-1:0] div_r;
  logic [SQ_W-1:0]       sq_r;
  logic [FIELD_W-1:0]    res_value_r;
  logic                  res_found_r;
  logic                  out_valid_r;
  logic [FIELD_W-1:0]    out_value_r;
  logic                  out_found_r;

  logic [VALUE_BITS-1:0] lo_val, hi_val;
  logic [CAND_W-1:0]     hi_ext;
  logic                  past_hi;
  logic                  below_two;
  logic                  sq_over;
  logic                  out_free;

  // Bounds taken at the value width
  assign lo_val    = VALUE_BITS'(lower_r);
  assign hi_val    = VALUE_BITS'(upper_r);
  assign hi_ext    = {1'b0, hi_val};
  assign past_hi   = (cand_r > hi_ext);
  assign below_two = (cand_r < CAND_W'(2));
  assign sq_over   = (sq_r > {1'b0, cand_r});
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_BOUND_RST;
      upper_r <= UPPER_BOUND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOWER_BOUND: lower_r <= cfg_data;
        REG_UPPER_BOUND: upper_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (past_hi) begin
          state_nxt = S_DONE;
        end else if (!below_two) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sq_over) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          state_nxt = rem_stat.zero ? S_CHECK : S_TEST;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer: control strobes
  always_comb begin
    ctrl = '0;
    case (state_r)
      S_IDLE: begin
        ctrl.load_pos = in_valid && (in_restart || !started_r);
      end
      S_CHECK: begin
        if (past_hi) begin
          ctrl.res_none = 1'b1;
        end else if (below_two) begin
          ctrl.cand_inc = 1'b1;
        end else begin
          ctrl.div_init = 1'b1;
        end
      end
      S_TEST: begin
        if (sq_over) begin
          ctrl.res_prime = 1'b1;
          ctrl.cand_inc  = 1'b1;
        end else begin
          ctrl.rem_start = 1'b1;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          ctrl.cand_inc = rem_stat.zero;
          ctrl.div_adv  = !rem_stat.zero;
        end
      end
      S_DONE: begin
        ctrl.out_load = out_free;
      end
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // Hold control state: sequencer, scan position, started flag, output word flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cand_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.load_pos) begin
        cand_r <= CAND_W'(lo_val);
      end else if (ctrl.cand_inc) begin
        cand_r <= cand_r + 1'b1;
      end
      if (in_valid && !in_stall) started_r <= 1'b1;
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Advance divisor and its square: (d+1)^2 = d^2 + 2d + 1
  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      div_r <= VALUE_BITS'(2);
      sq_r  <= SQ_W'(4);
    end else if (ctrl.div_adv) begin
      div_r <= div_r + 1'b1;
      sq_r  <= sq_r + SQ_W'({div_r, 1'b1});
    end
  end

  // Capture the result, then pass it to the output register
  always_ff @(posedge clk) begin
    if (ctrl.res_prime) begin
      res_value_r <= FIELD_W'(cand_r);
      res_found_r <= 1'b1;
    end else if (ctrl.res_none) begin
      res_value_r <= '0;
      res_found_r <= 1'b0;
    end
    if (ctrl.out_load) begin
      out_value_r <= res_value_r;
      out_found_r <= res_found_r;
    end
  end

  tdps_rem_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.rem_start),
    .dividend (cand_r[VALUE_BITS-1:0]),
    .divisor  (div_r),
    .stat     (rem_stat)
  );

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_found       = out_found_r;

  // An accepted word keeps the input stalled on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // The remainder unit reports only while the sequencer waits on it
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> state_r == S_DIV)
    else $error("remainder done outside divide state");

  // A divisor test only runs on a candidate inside the range and at least two
  a_test_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEST |-> !past_hi && !below_two)
    else $error("divisor test on candidate out of range");

  // A not-found word carries a zero value
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_value_r == '0)
    else $error("not-found word with non-zero value");

  // A loaded output word stays valid until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_value_r))
    else $error("stalled output word dropped");

endmodule

// File: verif/tb_trial_division_prime_scan.sv
module tb_trial_division_prime_scan;
  import tdps_pkg::*;

  localparam int TOTAL_REQUESTS = 1450;
  localparam int CALM_TAIL      = 150;
  localparam int SETTLE_CYCLES  = 50;

  // Indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] prime_value;
    logic               found;
  } scan_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FIELD_W-1:0]   out_prime_value;
  logic                 out_found;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOWER_BOUND;
  logic [FIELD_W-1:0]   cfg_data = '0;

  // Shadow of the block: bounds, scan position and whether a scan was loaded
  logic [FIELD_W-1:0]   lo_bound  = LOWER_BOUND_RST;
  logic [FIELD_W-1:0]   hi_bound  = UPPER_BOUND_RST;
  logic [FIELD_W:0]     scan_pos  = '0;
  bit                   scan_live = 1'b0;

  scan_result_t         pending_primes[$];
  int                   mismatches = 0;
  int                   requests_sent = 0;
  bit                   idle_on = 1'b0;
  int                   stall_left = 0;

  trial_division_prime_scan u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_prime_value (out_prime_value),
    .out_found       (out_found),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_prime_num(int unsigned n);
    if (n < 2) return 1'b0;
    for (int unsigned d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the shadow scan by one request and return the word it should give
  function automatic scan_result_t scan_for_prime(bit restart);
    scan_result_t res;
    int unsigned  n;
    res = '0;
    if (restart || !scan_live) begin
      scan_pos  = {1'b0, lo_bound};
      scan_live = 1'b1;
    end
    for (n = 32'(scan_pos); n <= hi_bound; n++) begin
      if (is_prime_num(n)) begin
        scan_pos        = (FIELD_W+1)'(n + 1);
        res.prime_value = n[FIELD_W-1:0];
        res.found       = 1'b1;
        return res;
      end
    end
    // Park the position just past the upper bound once the range runs dry
    if (scan_pos <= hi_bound) scan_pos = hi_bound + 17'd1;
    return res;
  endfunction

  // Result stall: random bursts while idling is on, clear otherwise
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 9);
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_primes.size() == 0) begin
        $error("unexpected result word: prime_value %0d found %0b", out_prime_value, out_found);
        mismatches++;
      end else begin
        want = pending_primes.pop_front();
        if (out_prime_value !== want.prime_value) begin
          $error("prime_value: expected %0d, got %0d", want.prime_value, out_prime_value);
          mismatches++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_found);
          mismatches++;
        end
      end
    end
  end

  // Send one request; returns at a falling edge with valid still high
  task automatic request_prime(bit restart);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid   = 1'b0;
      in_restart = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_restart = restart;
    do @(posedge clk); while (in_stall);
    pending_primes.push_back(scan_for_prime(restart));
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted word has arrived
  task automatic drain;
    in_valid = 1'b0;
    while (pending_primes.size() != 0) @(negedge clk);
  endtask

  task automatic write_bound_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LOWER_BOUND) lo_bound = data;
    else if (idx == REG_UPPER_BOUND) hi_bound = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // First request after reset loads from the lower bound without restart
  task automatic test_reset_defaults;
    request_prime(1'b0);
    request_prime(1'b0);
    request_prime(1'b1);
  endtask

  // Exhaust a range, raise the upper bound past the parked position,
  // change the lower bound mid-scan and hit an empty range
  task automatic test_exhaust_and_extend;
    write_bound_reg(REG_LOWER_BOUND, 16'd10);
    write_bound_reg(REG_UPPER_BOUND, 16'd12);
    request_prime(1'b1);
    request_prime(1'b0);
    request_prime(1'b0);
    write_bound_reg(REG_UPPER_BOUND, 16'd20);
    request_prime(1'b0);
    write_bound_reg(REG_LOWER_BOUND, 16'd1000);
    request_prime(1'b0);
    request_prime(1'b1);
    write_bound_reg(REG_UPPER_BOUND, 16'd1020);
    request_prime(1'b0);
  endtask

  // Top and bottom of the value range, including the 17-bit parked position
  task automatic test_bound_extremes;
    write_bound_reg(REG_LOWER_BOUND, 16'hFFFF);
    write_bound_reg(REG_UPPER_BOUND, 16'hFFFF);
    request_prime(1'b1);
    request_prime(1'b0);
    write_bound_reg(REG_LOWER_BOUND, 16'd65521);
    request_prime(1'b1);
    request_prime(1'b0);
    write_bound_reg(REG_LOWER_BOUND, 16'd0);
    write_bound_reg(REG_UPPER_BOUND, 16'd0);
    request_prime(1'b1);
    write_bound_reg(REG_UPPER_BOUND, 16'd1);
    request_prime(1'b1);
    write_bound_reg(REG_UPPER_BOUND, 16'd2);
    request_prime(1'b1);
  endtask

  task automatic test_unused_registers;
    write_bound_reg(REG_SPARE_2, 16'($urandom));
    write_bound_reg(REG_SPARE_3, 16'($urandom));
    request_prime(1'b0);
    request_prime(1'b1);
  endtask

  // Random phases: mostly small ranges to keep the division cheap,
  // a few near the top of the value range
  task automatic test_random_scans;
    int          pick;
    int          burst;
    int          big_done;
    int unsigned lo;
    int unsigned hi;
    big_done = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      idle_on = (TOTAL_REQUESTS - requests_sent > CALM_TAIL) && ($urandom_range(0, 4) != 0);
      pick  = $urandom_range(0, 99);
      burst = $urandom_range(10, 50);
      if (pick < 4 && big_done < 3) begin
        big_done++;
        lo    = $urandom_range(60000, 65535);
        hi    = $urandom_range(lo, 65535);
        burst = 6;
      end else if (pick < 15) begin
        lo = $urandom_range(0, 4000);
        hi = lo + $urandom_range(0, 120);
      end else if (pick < 25) begin
        lo = $urandom_range(0, 800);
        hi = $urandom_range(0, lo);
      end else begin
        lo = $urandom_range(0, 700);
        hi = lo + $urandom_range(0, 250);
      end
      if (pick >= 90) hi = 65535;
      if (pick == 50) lo = 0;
      if ($urandom_range(0, 3) != 0) write_bound_reg(REG_LOWER_BOUND, lo[FIELD_W-1:0]);
      if ($urandom_range(0, 3) != 0) write_bound_reg(REG_UPPER_BOUND, hi[FIELD_W-1:0]);
      if ($urandom_range(0, 19) == 0) write_bound_reg(REG_SPARE_2, 16'($urandom));
      request_prime(1'($urandom_range(0, 1)));
      repeat (burst - 1) begin
        if (requests_sent >= TOTAL_REQUESTS) break;
        request_prime($urandom_range(0, 4) == 0);
      end
    end
    idle_on = 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n   = 1'b1;
    idle_on = 1'b1;
    test_reset_defaults();
    test_exhaust_and_extend();
    test_bound_extremes();
    test_unused_registers();
    test_random_scans();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(64'd400_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/core/tdps_pkg.sv
rtl/core/tdps_rem_unit.sv
rtl/core/trial_division_prime_scan.sv
verif/tb_trial_division_prime_scan.sv
